### design/cpu6502_execute_unit_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CPU6502_EXECUTE_UNIT_CORE_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define C6502EU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define C6502EU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/c6502eu_pkg.sv
package c6502eu_pkg;

  // Status bit positions, NV1BDIZC
  localparam int unsigned FLAG_C   = 0;
  localparam int unsigned FLAG_Z   = 1;
  localparam int unsigned FLAG_I   = 2;
  localparam int unsigned FLAG_D   = 3;
  localparam int unsigned FLAG_B   = 4;
  localparam int unsigned FLAG_ONE = 5;
  localparam int unsigned FLAG_V   = 6;
  localparam int unsigned FLAG_N   = 7;

  localparam logic [7:0] RESET_SP     = 8'hFD;
  localparam logic [7:0] RESET_STATUS = 8'h24;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0] store_data;
    logic       store_enable;
    logic       stack_access;
    logic       branch_taken;
    logic       illegal_op;
    logic       stack_fault;
  } side_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] value;
  } mod_res_t;

  // Read-modify-write kinds, taken from opcode bits 7:5
  localparam logic [2:0] MOD_ASL = 3'd0;
  localparam logic [2:0] MOD_ROL = 3'd1;
  localparam logic [2:0] MOD_LSR = 3'd2;
  localparam logic [2:0] MOD_ROR = 3'd3;
  localparam logic [2:0] MOD_DEC = 3'd6;
  localparam logic [2:0] MOD_INC = 3'd7;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] f;
    f = p;
    f[FLAG_Z] = (v == 8'h00);
    f[FLAG_N] = v[7];
    return f;
  endfunction

  // CMP/CPX/CPY: carry is "no borrow", N and Z from the difference
  function automatic logic [7:0] compare(input logic [7:0] p, input logic [7:0] r,
                                         input logic [7:0] m);
    logic [8:0] diff;
    logic [7:0] f;
    diff = {1'b0, r} - {1'b0, m};
    f = set_nz(p, diff[7:0]);
    f[FLAG_C] = ~diff[8];
    return f;
  endfunction

  function automatic mod_res_t modify(input logic [2:0] kind, input logic [7:0] p,
                                      input logic [7:0] v);
    mod_res_t res;
    res.flags = p;
    case (kind)
      MOD_ASL: begin
        res.flags[FLAG_C] = v[7];
        res.value = {v[6:0], 1'b0};
      end
      MOD_ROL: begin
        res.flags[FLAG_C] = v[7];
        res.value = {v[6:0], p[FLAG_C]};
      end
      MOD_LSR: begin
        res.flags[FLAG_C] = v[0];
        res.value = {1'b0, v[7:1]};
      end
      MOD_ROR: begin
        res.flags[FLAG_C] = v[0];
        res.value = {p[FLAG_C], v[7:1]};
      end
      MOD_DEC: res.value = v - 8'd1;
      default: res.value = v + 8'd1;
    endcase
    res.flags = set_nz(res.flags, res.value);
    return res;
  endfunction

endpackage

### design/cpu6502_execute_unit_core.sv
// 6502 execute stage, binary arithmetic only. Each transaction on the item
// channel carries one opcode and its operand byte (for PLP and PLA, the byte at
// 0x100 plus the incremented pointer) and produces exactly one transaction on
// the result channel with A, X, Y, SP and status after the instruction plus
// the store, stack, branch and fault indications. The unit takes one
// instruction per clock while no result is stalled: decode, ALU and flag
// logic are combinational against the architectural registers, which update
// at the edge that accepts the item, so a dependent instruction may follow in
// the next cycle. Results appear in the result register in the cycle after
// acceptance; item_ready drops only while a result waits with result_ready
// low. Illegal opcodes leave all registers unchanged and report illegal_op.
module cpu6502_execute_unit_core
  import c6502eu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,

  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] op,
  input  logic [7:0] operand,

  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] acc_out,
  output logic [7:0] index_x_out,
  output logic [7:0] index_y_out,
  output logic [7:0] flags_out,
  output logic [7:0] stack_ptr_out,
  output logic [7:0] store_data,
  output logic       store_enable,
  output logic       stack_access,
  output logic       branch_taken,
  output logic       illegal_op,
  output logic       stack_fault
);

  regs_t regs;
  regs_t regs_next;
  side_t side_next;
  regs_t res_regs;
  side_t res_side;
  logic  accept;

  c6502eu_exec u_exec (
    .op      (op),
    .operand (operand),
    .cur     (regs),
    .nxt     (regs_next),
    .side    (side_next)
  );

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.acc     <= 8'h00;
      regs.x       <= 8'h00;
      regs.y       <= 8'h00;
      regs.s       <= RESET_SP;
      regs.p       <= RESET_STATUS;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        regs         <= regs_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload; loads only on acceptance, so it holds while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_regs <= regs_next;
      res_side <= side_next;
    end
  end

  assign acc_out       = res_regs.acc;
  assign index_x_out   = res_regs.x;
  assign index_y_out   = res_regs.y;
  assign flags_out     = res_regs.p;
  assign stack_ptr_out = res_regs.s;
  assign store_data    = res_side.store_data;
  assign store_enable  = res_side.store_enable;
  assign stack_access  = res_side.stack_access;
  assign branch_taken  = res_side.branch_taken;
  assign illegal_op    = res_side.illegal_op;
  assign stack_fault   = res_side.stack_fault;

endmodule

### design/c6502eu_exec.sv
module c6502eu_exec
  import c6502eu_pkg::*;
(
  input  logic [7:0] op,
  input  logic [7:0] operand,
  input  regs_t      cur,
  output regs_t      nxt,
  output side_t      side
);

  // Opcode column, op[1:0]
  localparam logic [1:0] GRP_CTRL = 2'd0;
  localparam logic [1:0] GRP_ALU  = 2'd1;
  localparam logic [1:0] GRP_RMW  = 2'd2;

  // Addressing row, op[4:2]
  localparam logic [2:0] MODE_IMM    = 3'd0;
  localparam logic [2:0] MODE_IMPL   = 3'd2;
  localparam logic [2:0] MODE_IND    = 3'd4;
  localparam logic [2:0] MODE_SINGLE = 3'd6;

  // ALU operations, op[7:5]
  localparam logic [2:0] ALU_ORA = 3'd0;
  localparam logic [2:0] ALU_AND = 3'd1;
  localparam logic [2:0] ALU_EOR = 3'd2;
  localparam logic [2:0] ALU_ADC = 3'd3;
  localparam logic [2:0] ALU_STA = 3'd4;
  localparam logic [2:0] ALU_LDA = 3'd5;
  localparam logic [2:0] ALU_CMP = 3'd6;

  // Control column, implied row
  localparam logic [2:0] IMP_PHP = 3'd0;
  localparam logic [2:0] IMP_PLP = 3'd1;
  localparam logic [2:0] IMP_PHA = 3'd2;
  localparam logic [2:0] IMP_PLA = 3'd3;
  localparam logic [2:0] IMP_DEY = 3'd4;
  localparam logic [2:0] IMP_TAY = 3'd5;
  localparam logic [2:0] IMP_INY = 3'd6;

  // Control column, single-byte row
  localparam logic [2:0] SGL_CLC = 3'd0;
  localparam logic [2:0] SGL_SEC = 3'd1;
  localparam logic [2:0] SGL_CLI = 3'd2;
  localparam logic [2:0] SGL_SEI = 3'd3;
  localparam logic [2:0] SGL_TYA = 3'd4;
  localparam logic [2:0] SGL_CLV = 3'd5;
  localparam logic [2:0] SGL_CLD = 3'd6;

  // Control column, operand rows
  localparam logic [2:0] CTL_BIT = 3'd1;
  localparam logic [2:0] CTL_STY = 3'd4;
  localparam logic [2:0] CTL_LDY = 3'd5;
  localparam logic [2:0] CTL_CPY = 3'd6;

  // Read-modify-write column, implied row
  localparam logic [2:0] RMW_TXA = 3'd4;
  localparam logic [2:0] RMW_TAX = 3'd5;
  localparam logic [2:0] RMW_DEX = 3'd6;
  localparam logic [2:0] RMW_STX = 3'd4;
  localparam logic [2:0] RMW_LDX = 3'd5;

  // Branch condition flag, op[7:6]
  localparam logic [1:0] BR_N = 2'd0;
  localparam logic [1:0] BR_V = 2'd1;
  localparam logic [1:0] BR_C = 2'd2;

  localparam logic [7:0] OP_NOP_IMM = 8'h89;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_SHX     = 8'h9E;

  // Legal operations of the control column by row, one bit per op[7:5]
  localparam logic [7:0] CTRL_LEGAL [8] = '{8'hE0, 8'hF2, 8'h00, 8'hF2,
                                            8'h00, 8'h30, 8'h00, 8'h20};

  logic [2:0] hi;
  logic [2:0] mode;
  logic       do_push;
  logic       do_pull;
  logic [7:0] push_byte;
  logic       br_flag;
  logic [8:0] sum;
  mod_res_t   mres;

  assign hi   = op[7:5];
  assign mode = op[4:2];

  always_comb begin
    nxt       = cur;
    side      = '0;
    do_push   = 1'b0;
    do_pull   = 1'b0;
    push_byte = 8'h00;
    br_flag   = 1'b0;
    sum       = 9'h000;
    mres      = '0;

    case (op[1:0])
      GRP_CTRL: begin
        if (mode == MODE_IND) begin
          case (op[7:6])
            BR_N:    br_flag = cur.p[FLAG_N];
            BR_V:    br_flag = cur.p[FLAG_V];
            BR_C:    br_flag = cur.p[FLAG_C];
            default: br_flag = cur.p[FLAG_Z];
          endcase
          side.branch_taken = (br_flag == op[5]);
        end else if (mode == MODE_IMPL) begin
          case (hi)
            IMP_PHP: begin
              do_push   = 1'b1;
              push_byte = cur.p | 8'h30;
            end
            IMP_PLP: begin
              do_pull = 1'b1;
              nxt.p   = (operand & 8'hEF) | 8'h20;
            end
            IMP_PHA: begin
              do_push   = 1'b1;
              push_byte = cur.acc;
            end
            IMP_PLA: begin
              do_pull = 1'b1;
              nxt.acc = operand;
              nxt.p   = set_nz(cur.p, operand);
            end
            IMP_DEY: begin
              nxt.y = cur.y - 8'd1;
              nxt.p = set_nz(cur.p, nxt.y);
            end
            IMP_TAY: begin
              nxt.y = cur.acc;
              nxt.p = set_nz(cur.p, cur.acc);
            end
            IMP_INY: begin
              nxt.y = cur.y + 8'd1;
              nxt.p = set_nz(cur.p, nxt.y);
            end
            default: begin
              nxt.x = cur.x + 8'd1;
              nxt.p = set_nz(cur.p, nxt.x);
            end
          endcase
        end else if (mode == MODE_SINGLE) begin
          case (hi)
            SGL_CLC: nxt.p[FLAG_C] = 1'b0;
            SGL_SEC: nxt.p[FLAG_C] = 1'b1;
            SGL_CLI: nxt.p[FLAG_I] = 1'b0;
            SGL_SEI: nxt.p[FLAG_I] = 1'b1;
            SGL_TYA: begin
              nxt.acc = cur.y;
              nxt.p   = set_nz(cur.p, cur.y);
            end
            SGL_CLV: nxt.p[FLAG_V] = 1'b0;
            SGL_CLD: nxt.p[FLAG_D] = 1'b0;
            default: nxt.p[FLAG_D] = 1'b1;
          endcase
        end else if (!CTRL_LEGAL[mode][hi]) begin
          side.illegal_op = 1'b1;
        end else begin
          case (hi)
            CTL_BIT: begin
              nxt.p[FLAG_N] = operand[7];
              nxt.p[FLAG_V] = operand[6];
              nxt.p[FLAG_Z] = ((cur.acc & operand) == 8'h00);
            end
            CTL_STY: begin
              side.store_enable = 1'b1;
              side.store_data   = cur.y;
            end
            CTL_LDY: begin
              nxt.y = operand;
              nxt.p = set_nz(cur.p, operand);
            end
            CTL_CPY: nxt.p = compare(cur.p, cur.y, operand);
            default: nxt.p = compare(cur.p, cur.x, operand);
          endcase
        end
      end

      GRP_ALU: begin
        if (op == OP_NOP_IMM) begin
          side.illegal_op = 1'b1;
        end else begin
          case (hi)
            ALU_ORA: begin
              nxt.acc = cur.acc | operand;
              nxt.p   = set_nz(cur.p, nxt.acc);
            end
            ALU_AND: begin
              nxt.acc = cur.acc & operand;
              nxt.p   = set_nz(cur.p, nxt.acc);
            end
            ALU_EOR: begin
              nxt.acc = cur.acc ^ operand;
              nxt.p   = set_nz(cur.p, nxt.acc);
            end
            ALU_ADC: begin
              sum     = {1'b0, cur.acc} + {1'b0, operand} + {8'h00, cur.p[FLAG_C]};
              nxt.acc = sum[7:0];
              nxt.p   = set_nz(cur.p, sum[7:0]);
              nxt.p[FLAG_C] = sum[8];
              nxt.p[FLAG_V] = ~(cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ sum[7]);
            end
            ALU_STA: begin
              side.store_enable = 1'b1;
              side.store_data   = cur.acc;
            end
            ALU_LDA: begin
              nxt.acc = operand;
              nxt.p   = set_nz(cur.p, operand);
            end
            ALU_CMP: nxt.p = compare(cur.p, cur.acc, operand);
            default: begin
              // SBC as A + ~M + C; carry out is "no borrow"
              sum     = {1'b0, cur.acc} + {1'b0, ~operand} + {8'h00, cur.p[FLAG_C]};
              nxt.acc = sum[7:0];
              nxt.p   = set_nz(cur.p, sum[7:0]);
              nxt.p[FLAG_C] = sum[8];
              nxt.p[FLAG_V] = (cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ sum[7]);
            end
          endcase
        end
      end

      GRP_RMW: begin
        if (mode == MODE_IMM) begin
          if (op == OP_LDX_IMM) begin
            nxt.x = operand;
            nxt.p = set_nz(cur.p, operand);
          end else begin
            side.illegal_op = 1'b1;
          end
        end else if (mode == MODE_IMPL) begin
          if (!hi[2]) begin
            mres    = modify(hi, cur.p, cur.acc);
            nxt.acc = mres.value;
            nxt.p   = mres.flags;
          end else if (hi == RMW_TXA) begin
            nxt.acc = cur.x;
            nxt.p   = set_nz(cur.p, cur.x);
          end else if (hi == RMW_TAX) begin
            nxt.x = cur.acc;
            nxt.p = set_nz(cur.p, cur.acc);
          end else if (hi == RMW_DEX) begin
            nxt.x = cur.x - 8'd1;
            nxt.p = set_nz(cur.p, nxt.x);
          end
        end else if (mode == MODE_SINGLE) begin
          if (op == OP_TXS) begin
            nxt.s = cur.x;
          end else if (op == OP_TSX) begin
            nxt.x = cur.s;
            nxt.p = set_nz(cur.p, cur.s);
          end else begin
            side.illegal_op = 1'b1;
          end
        end else if (mode == MODE_IND || op == OP_SHX) begin
          side.illegal_op = 1'b1;
        end else if (hi == RMW_STX) begin
          side.store_enable = 1'b1;
          side.store_data   = cur.x;
        end else if (hi == RMW_LDX) begin
          nxt.x = operand;
          nxt.p = set_nz(cur.p, operand);
        end else begin
          mres              = modify(hi, cur.p, operand);
          nxt.p             = mres.flags;
          side.store_enable = 1'b1;
          side.store_data   = mres.value;
        end
      end

      default: side.illegal_op = 1'b1;
    endcase

    // Stack side effects; the pointer wraps on a fault
    if (do_push) begin
      side.store_enable = 1'b1;
      side.store_data   = push_byte;
      side.stack_access = 1'b1;
      side.stack_fault  = (cur.s == 8'h00);
      nxt.s             = cur.s - 8'd1;
    end else if (do_pull) begin
      side.stack_access = 1'b1;
      side.stack_fault  = (cur.s == 8'hFF);
      nxt.s             = cur.s + 8'd1;
    end
  end

endmodule

### design/c6502eu_checker.sv
`include "cpu6502_execute_unit_core_defines.svh"

module c6502eu_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] acc_out,
  input logic [7:0] flags_out,
  input logic [7:0] stack_ptr_out,
  input logic       store_enable,
  input logic       stack_access,
  input logic       branch_taken,
  input logic       illegal_op,
  input logic       stack_fault
);

  // A stalled result keeps its register values
  `C6502EU_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(acc_out) && $stable(flags_out) && $stable(stack_ptr_out), "result changed while stalled")

  // Input side backs up only behind a stalled result
  `C6502EU_ASSERT_NOW(a_ready_only_stall, clk, rst, !item_ready, result_valid && !result_ready, "item_ready low without a stalled result")

  // Illegal opcodes produce no side effects
  `C6502EU_ASSERT_NOW(a_illegal_quiet, clk, rst, result_valid && illegal_op, !store_enable && !stack_access && !branch_taken && !stack_fault, "illegal opcode with side effects")

  // Faults come only from stack accesses
  `C6502EU_ASSERT_NOW(a_fault_on_stack, clk, rst, result_valid && stack_fault, stack_access, "stack fault without stack access")

  // Status bit 5 is always set
  `C6502EU_ASSERT_NOW(a_flag_one, clk, rst, result_valid, flags_out[5], "status bit 5 clear")

endmodule

bind cpu6502_execute_unit_core c6502eu_checker u_c6502eu_checker (.*);

### sim/cpu6502_retire_checker.sv
package c6502eu_tb_pkg;

  // Opcode column groups, taken from opcode bits 1:0
  localparam logic [1:0] CC_CONTROL = 2'd0;
  localparam logic [1:0] CC_ALU     = 2'd1;
  localparam logic [1:0] CC_RMW     = 2'd2;
  localparam logic [1:0] CC_UNDOC   = 2'd3;

  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_PHP     = 8'h08;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_PLP     = 8'h28;
  localparam logic [7:0] OP_BMI     = 8'h30;
  localparam logic [7:0] OP_PHA     = 8'h48;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_PLA     = 8'h68;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_ROR_ACC = 8'h6A;
  localparam logic [7:0] OP_BVS     = 8'h70;
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STA_IMM = 8'h89;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_SHX     = 8'h9E;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_SED     = 8'hF8;

endpackage

module cpu6502_retire_checker
  import c6502eu_pkg::*;
  import c6502eu_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_ready,
  input  logic [7:0] op,
  input  logic [7:0] operand,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [7:0] acc_out,
  input  logic [7:0] index_x_out,
  input  logic [7:0] index_y_out,
  input  logic [7:0] flags_out,
  input  logic [7:0] stack_ptr_out,
  input  logic [7:0] store_data,
  input  logic       store_enable,
  input  logic       stack_access,
  input  logic       branch_taken,
  input  logic       illegal_op,
  input  logic       stack_fault,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Addressing columns, opcode bits 4:2
  localparam logic [2:0] MODE_IMM   = 3'd0;
  localparam logic [2:0] MODE_ZP    = 3'd1;
  localparam logic [2:0] MODE_IMPL  = 3'd2;
  localparam logic [2:0] MODE_ABS   = 3'd3;
  localparam logic [2:0] MODE_IND_Y = 3'd4;
  localparam logic [2:0] MODE_ZP_X  = 3'd5;
  localparam logic [2:0] MODE_ABS_Y = 3'd6;
  localparam logic [2:0] MODE_ABS_X = 3'd7;

  // Control group, implied column
  localparam logic [2:0] IMP_PHP = 3'd0;
  localparam logic [2:0] IMP_PLP = 3'd1;
  localparam logic [2:0] IMP_PHA = 3'd2;
  localparam logic [2:0] IMP_PLA = 3'd3;
  localparam logic [2:0] IMP_DEY = 3'd4;
  localparam logic [2:0] IMP_TAY = 3'd5;
  localparam logic [2:0] IMP_INY = 3'd6;

  // Control group, flag column
  localparam logic [2:0] FLG_CLC = 3'd0;
  localparam logic [2:0] FLG_SEC = 3'd1;
  localparam logic [2:0] FLG_CLI = 3'd2;
  localparam logic [2:0] FLG_SEI = 3'd3;
  localparam logic [2:0] FLG_TYA = 3'd4;
  localparam logic [2:0] FLG_CLV = 3'd5;
  localparam logic [2:0] FLG_CLD = 3'd6;

  // Control group, memory columns
  localparam logic [2:0] CTL_BIT = 3'd1;
  localparam logic [2:0] CTL_STY = 3'd4;
  localparam logic [2:0] CTL_LDY = 3'd5;
  localparam logic [2:0] CTL_CPY = 3'd6;

  // Read-modify-write group rows that are not shifts or steps
  localparam logic [2:0] RMW_STX = 3'd4;
  localparam logic [2:0] RMW_LDX = 3'd5;

  localparam logic [2:0] RMW_CPX_ROW = 3'd7;

  // Branch flag select, opcode bits 7:6
  localparam logic [1:0] BR_N = 2'd0;
  localparam logic [1:0] BR_V = 2'd1;
  localparam logic [1:0] BR_C = 2'd2;

  localparam int MAX_REPORTS = 200;

  typedef enum logic [2:0] {
    ALU_ORA, ALU_AND, ALU_EOR, ALU_ADC, ALU_STA, ALU_LDA, ALU_CMP, ALU_SBC
  } alu_op_e;

  typedef struct packed {
    regs_t regs;
    side_t side;
  } retire_t;

  regs_t   arch_regs;
  side_t   instr_side;
  retire_t expected_retires[$];

  function automatic void update_nz(input logic [7:0] v);
    arch_regs.p[FLAG_Z] = (v == 8'h00);
    arch_regs.p[FLAG_N] = v[7];
  endfunction

  function automatic void compare_with(input logic [7:0] r, input logic [7:0] m);
    logic [8:0] diff;
    diff = {1'b0, r} - {1'b0, m};
    arch_regs.p[FLAG_C] = ~diff[8];
    update_nz(diff[7:0]);
  endfunction

  function automatic logic [7:0] shift_or_step(input logic [2:0] kind, input logic [7:0] v);
    logic [7:0] r;
    logic       cin;
    cin = arch_regs.p[FLAG_C];
    case (kind)
      MOD_ASL: begin
        arch_regs.p[FLAG_C] = v[7];
        r = {v[6:0], 1'b0};
      end
      MOD_ROL: begin
        arch_regs.p[FLAG_C] = v[7];
        r = {v[6:0], cin};
      end
      MOD_LSR: begin
        arch_regs.p[FLAG_C] = v[0];
        r = {1'b0, v[7:1]};
      end
      MOD_ROR: begin
        arch_regs.p[FLAG_C] = v[0];
        r = {cin, v[7:1]};
      end
      MOD_DEC: r = v - 8'd1;
      default: r = v + 8'd1;
    endcase
    update_nz(r);
    return r;
  endfunction

  function automatic void store_byte(input logic [7:0] v);
    instr_side.store_enable = 1'b1;
    instr_side.store_data   = v;
  endfunction

  // A push at pointer zero still writes page one, then wraps
  function automatic void push_byte(input logic [7:0] v);
    store_byte(v);
    instr_side.stack_access = 1'b1;
    instr_side.stack_fault  = (arch_regs.s == 8'h00);
    arch_regs.s = arch_regs.s - 8'd1;
  endfunction

  function automatic void pull_byte();
    instr_side.stack_access = 1'b1;
    instr_side.stack_fault  = (arch_regs.s == 8'hFF);
    arch_regs.s = arch_regs.s + 8'd1;
  endfunction

  function automatic void exec_control(input logic [7:0] opc, input logic [7:0] m);
    logic [2:0] row;
    logic [2:0] mode;
    logic       flag;
    logic       legal;
    row  = opc[7:5];
    mode = opc[4:2];
    if (mode == MODE_IND_Y) begin
      // this column holds the conditional branches
      case (opc[7:6])
        BR_N:    flag = arch_regs.p[FLAG_N];
        BR_V:    flag = arch_regs.p[FLAG_V];
        BR_C:    flag = arch_regs.p[FLAG_C];
        default: flag = arch_regs.p[FLAG_Z];
      endcase
      instr_side.branch_taken = (flag == opc[5]);
    end else if (mode == MODE_IMPL) begin
      case (row)
        IMP_PHP: begin
          flag = 1'b1;
          push_byte(arch_regs.p | (8'd1 << FLAG_B) | (8'd1 << FLAG_ONE));
        end
        IMP_PLP: begin
          pull_byte();
          arch_regs.p = m;
          arch_regs.p[FLAG_B]   = 1'b0;
          arch_regs.p[FLAG_ONE] = 1'b1;
        end
        IMP_PHA: push_byte(arch_regs.acc);
        IMP_PLA: begin
          pull_byte();
          arch_regs.acc = m;
          update_nz(m);
        end
        IMP_DEY: begin
          arch_regs.y = arch_regs.y - 8'd1;
          update_nz(arch_regs.y);
        end
        IMP_TAY: begin
          arch_regs.y = arch_regs.acc;
          update_nz(arch_regs.y);
        end
        IMP_INY: begin
          arch_regs.y = arch_regs.y + 8'd1;
          update_nz(arch_regs.y);
        end
        default: begin
          arch_regs.x = arch_regs.x + 8'd1;
          update_nz(arch_regs.x);
        end
      endcase
    end else if (mode == MODE_ABS_Y) begin
      case (row)
        FLG_CLC: arch_regs.p[FLAG_C] = 1'b0;
        FLG_SEC: arch_regs.p[FLAG_C] = 1'b1;
        FLG_CLI: arch_regs.p[FLAG_I] = 1'b0;
        FLG_SEI: arch_regs.p[FLAG_I] = 1'b1;
        FLG_TYA: begin
          arch_regs.acc = arch_regs.y;
          update_nz(arch_regs.acc);
        end
        FLG_CLV: arch_regs.p[FLAG_V] = 1'b0;
        FLG_CLD: arch_regs.p[FLAG_D] = 1'b0;
        default: arch_regs.p[FLAG_D] = 1'b1;
      endcase
    end else begin
      // BRK, JSR, RTI, RTS and both JMPs fall out here as illegal
      case (mode)
        MODE_IMM:           legal = row inside {CTL_LDY, CTL_CPY, RMW_CPX_ROW};
        MODE_ZP, MODE_ABS:  legal = row inside {CTL_BIT, CTL_STY, CTL_LDY, CTL_CPY,
                                                RMW_CPX_ROW};
        MODE_ZP_X:          legal = row inside {CTL_STY, CTL_LDY};
        MODE_ABS_X:         legal = (row == CTL_LDY);
        default:            legal = 1'b0;
      endcase
      if (!legal) begin
        instr_side.illegal_op = 1'b1;
      end else begin
        case (row)
          CTL_BIT: begin
            arch_regs.p[FLAG_N] = m[7];
            arch_regs.p[FLAG_V] = m[6];
            arch_regs.p[FLAG_Z] = ((arch_regs.acc & m) == 8'h00);
          end
          CTL_STY: store_byte(arch_regs.y);
          CTL_LDY: begin
            arch_regs.y = m;
            update_nz(m);
          end
          CTL_CPY: compare_with(arch_regs.y, m);
          default: compare_with(arch_regs.x, m);
        endcase
      end
    end
  endfunction

  function automatic void exec_alu(input logic [7:0] opc, input logic [7:0] m);
    logic [7:0] a;
    logic [8:0] sum;
    logic       borrow;
    a = arch_regs.acc;
    if (opc == OP_STA_IMM) begin
      instr_side.illegal_op = 1'b1;
    end else begin
      case (alu_op_e'(opc[7:5]))
        ALU_ORA: begin
          arch_regs.acc = a | m;
          update_nz(arch_regs.acc);
        end
        ALU_AND: begin
          arch_regs.acc = a & m;
          update_nz(arch_regs.acc);
        end
        ALU_EOR: begin
          arch_regs.acc = a ^ m;
          update_nz(arch_regs.acc);
        end
        ALU_ADC: begin
          sum = {1'b0, a} + {1'b0, m} + {8'd0, arch_regs.p[FLAG_C]};
          arch_regs.p[FLAG_C] = sum[8];
          arch_regs.p[FLAG_V] = (a[7] == m[7]) && (sum[7] != a[7]);
          arch_regs.acc = sum[7:0];
          update_nz(sum[7:0]);
        end
        ALU_STA: store_byte(a);
        ALU_LDA: begin
          arch_regs.acc = m;
          update_nz(m);
        end
        ALU_CMP: compare_with(a, m);
        default: begin
          borrow = ~arch_regs.p[FLAG_C];
          sum = {1'b0, a} - {1'b0, m} - {8'd0, borrow};
          arch_regs.p[FLAG_C] = ~sum[8];
          arch_regs.p[FLAG_V] = (a[7] != m[7]) && (sum[7] != a[7]);
          arch_regs.acc = sum[7:0];
          update_nz(sum[7:0]);
        end
      endcase
    end
  endfunction

  function automatic void exec_rmw(input logic [7:0] opc, input logic [7:0] m);
    logic [2:0] row;
    logic [2:0] mode;
    row  = opc[7:5];
    mode = opc[4:2];
    if (mode == MODE_IMM) begin
      if (opc == OP_LDX_IMM) begin
        arch_regs.x = m;
        update_nz(m);
      end else begin
        instr_side.illegal_op = 1'b1;
      end
    end else if (mode == MODE_IMPL) begin
      if (row inside {MOD_ASL, MOD_ROL, MOD_LSR, MOD_ROR}) begin
        arch_regs.acc = shift_or_step(row, arch_regs.acc);
      end else if (row == RMW_STX) begin
        arch_regs.acc = arch_regs.x;
        update_nz(arch_regs.acc);
      end else if (row == RMW_LDX) begin
        arch_regs.x = arch_regs.acc;
        update_nz(arch_regs.x);
      end else if (row == MOD_DEC) begin
        arch_regs.x = arch_regs.x - 8'd1;
        update_nz(arch_regs.x);
      end
      // the INC row of this column is NOP: nothing changes
    end else if (mode == MODE_ABS_Y) begin
      if (opc == OP_TXS) begin
        arch_regs.s = arch_regs.x;
      end else if (opc == OP_TSX) begin
        arch_regs.x = arch_regs.s;
        update_nz(arch_regs.x);
      end else begin
        instr_side.illegal_op = 1'b1;
      end
    end else if (mode == MODE_IND_Y || opc == OP_SHX) begin
      instr_side.illegal_op = 1'b1;
    end else if (row == RMW_STX) begin
      store_byte(arch_regs.x);
    end else if (row == RMW_LDX) begin
      arch_regs.x = m;
      update_nz(m);
    end else begin
      store_byte(shift_or_step(row, m));
    end
  endfunction

  function automatic retire_t execute_instr(input logic [7:0] opc, input logic [7:0] m);
    retire_t res;
    instr_side = '0;
    case (opc[1:0])
      CC_CONTROL: exec_control(opc, m);
      CC_ALU:     exec_alu(opc, m);
      CC_RMW:     exec_rmw(opc, m);
      default:    instr_side.illegal_op = 1'b1;
    endcase
    res.regs = arch_regs;
    res.side = instr_side;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : track
    retire_t want;
    if (rst) begin
      arch_regs = '{acc: 8'h00, x: 8'h00, y: 8'h00, s: RESET_SP, p: RESET_STATUS};
      expected_retires.delete();
      fail_count = 0;
    end else begin
      if (item_valid && item_ready) begin
        expected_retires.push_back(execute_instr(op, operand));
      end
      if (result_valid && result_ready) begin
        if (expected_retires.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected transaction, expected none, actual acc %h x %h y %h p %h s %h",
                     $time, acc_out, index_x_out, index_y_out, flags_out, stack_ptr_out);
          end
        end else begin
          want = expected_retires.pop_front();
          check_field("acc_out", want.regs.acc, acc_out);
          check_field("index_x_out", want.regs.x, index_x_out);
          check_field("index_y_out", want.regs.y, index_y_out);
          check_field("flags_out", want.regs.p, flags_out);
          check_field("stack_ptr_out", want.regs.s, stack_ptr_out);
          check_field("store_data", want.side.store_data, store_data);
          check_field("store_enable", {7'd0, want.side.store_enable}, {7'd0, store_enable});
          check_field("stack_access", {7'd0, want.side.stack_access}, {7'd0, stack_access});
          check_field("branch_taken", {7'd0, want.side.branch_taken}, {7'd0, branch_taken});
          check_field("illegal_op", {7'd0, want.side.illegal_op}, {7'd0, illegal_op});
          check_field("stack_fault", {7'd0, want.side.stack_fault}, {7'd0, stack_fault});
        end
      end
    end
    pending_count = expected_retires.size();
  end

endmodule

### sim/tb_cpu6502_execute_unit_core.sv
module tb_cpu6502_execute_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import c6502eu_tb_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CALM_ITEMS   = 150;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  logic [7:0] op;
  logic [7:0] operand;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] acc_out;
  logic [7:0] index_x_out;
  logic [7:0] index_y_out;
  logic [7:0] flags_out;
  logic [7:0] stack_ptr_out;
  logic [7:0] store_data;
  logic       store_enable;
  logic       stack_access;
  logic       branch_taken;
  logic       illegal_op;
  logic       stack_fault;
  int         fail_count;
  int         pending_count;

  int items_sent;
  int gap_free_items;
  int stall_cycles;
  bit calm;

  cpu6502_execute_unit_core uut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (op),
    .operand       (operand),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .acc_out       (acc_out),
    .index_x_out   (index_x_out),
    .index_y_out   (index_y_out),
    .flags_out     (flags_out),
    .stack_ptr_out (stack_ptr_out),
    .store_data    (store_data),
    .store_enable  (store_enable),
    .stack_access  (stack_access),
    .branch_taken  (branch_taken),
    .illegal_op    (illegal_op),
    .stack_fault   (stack_fault)
  );

  cpu6502_retire_checker chk (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (op),
    .operand       (operand),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .acc_out       (acc_out),
    .index_x_out   (index_x_out),
    .index_y_out   (index_y_out),
    .flags_out     (flags_out),
    .stack_ptr_out (stack_ptr_out),
    .store_data    (store_data),
    .store_enable  (store_enable),
    .stack_access  (stack_access),
    .branch_taken  (branch_taken),
    .illegal_op    (illegal_op),
    .stack_fault   (stack_fault),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_instr(input logic [7:0] opc, input logic [7:0] val);
    if (gap_free_items > 0) begin
      gap_free_items--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end else if ($urandom_range(0, 19) == 0) begin
      gap_free_items = $urandom_range(20, 60);
    end
    item_valid <= 1'b1;
    op         <= opc;
    operand    <= val;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Park the pointer near an edge of the stack, then push and pull around it.
  task automatic stack_burst();
    logic [7:0] start_sp;
    case ($urandom_range(0, 4))
      0:       start_sp = 8'h00;
      1:       start_sp = 8'h01;
      2:       start_sp = 8'hFE;
      3:       start_sp = 8'hFF;
      default: start_sp = 8'($urandom);
    endcase
    send_instr(OP_LDX_IMM, start_sp);
    send_instr(OP_TXS, pick_operand());
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0:       send_instr(OP_PHA, pick_operand());
        1:       send_instr(OP_PHP, pick_operand());
        2:       send_instr(OP_PLA, pick_operand());
        default: send_instr(OP_PLP, pick_operand());
      endcase
    end
  endtask

  // Hold result_ready low in bursts, with long stretches of no back-pressure.
  initial begin
    int steady;
    steady = 0;
    result_ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && steady == 0 && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else if (steady == 0 && $urandom_range(0, 15) == 0) begin
        steady = $urandom_range(20, 80);
      end
      if (steady > 0) steady--;
      result_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] directed[27];
    logic [7:0]  sweep_order[256];
    logic [7:0]  opc;
    logic [7:0]  tmp;
    int          j;

    rst            <= 1'b1;
    item_valid     <= 1'b0;
    op             <= 8'h00;
    operand        <= 8'h00;
    items_sent     = 0;
    gap_free_items = 0;
    calm           = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Arithmetic edges, stack wrap both ways, status push/pull, illegal opcodes
    directed = '{
      {OP_LDA_IMM, 8'h00}, {OP_LDA_IMM, 8'h7F}, {OP_ADC_IMM, 8'h01},
      {OP_ADC_IMM, 8'h80}, {OP_SBC_IMM, 8'hFF}, {OP_CMP_IMM, 8'h01},
      {OP_LDX_IMM, 8'h00}, {OP_TXS, 8'h55},     {OP_PHA, 8'h00},
      {OP_PLA, 8'hFF},     {OP_PHP, 8'h00},     {OP_PLP, 8'hFF},
      {OP_SED, 8'h00},     {OP_CLD, 8'hFF},     {OP_BIT_ZP, 8'h40},
      {OP_BVS, 8'h10},     {OP_BMI, 8'hF0},     {OP_ROR_ACC, 8'hAA},
      {OP_INC_ZP, 8'hFF},  {OP_DEC_ZP, 8'h00},  {OP_STY_ZP, 8'h12},
      {OP_CPX_IMM, 8'hFF}, {OP_TSX, 8'h00},     {OP_STA_IMM, 8'h33},
      {OP_SHX, 8'hC3},     {OP_JMP_ABS, 8'h00}, {OP_NOP, 8'hFF}
    };
    foreach (directed[i]) send_instr(directed[i][15:8], directed[i][7:0]);

    // Every opcode once, in shuffled order
    for (int i = 0; i < 256; i++) sweep_order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = sweep_order[i];
      sweep_order[i] = sweep_order[j];
      sweep_order[j] = tmp;
    end
    foreach (sweep_order[i]) send_instr(sweep_order[i], pick_operand());

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
      if ($urandom_range(0, 9) == 0) begin
        stack_burst();
      end else begin
        opc = 8'($urandom);
        // steer most undocumented-column picks back to executable opcodes
        if (opc[1:0] == CC_UNDOC && $urandom_range(0, 5) != 0) begin
          opc[1:0] = 2'($urandom_range(CC_CONTROL, CC_RMW));
        end
        send_instr(opc, pick_operand());
      end
    end
    item_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
